// File: rtl/core/qrpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrpm_pkg
// Shared types, widths and helpers for the rate controller and motor mixer.
// ----------------------------------------------------------------------------
package qrpm_pkg;

  localparam int RATE_W     = 16;
  localparam int ERR_W      = 17;
  localparam int GAIN_W     = 24;
  localparam int DB_W       = 15;
  localparam int THR_W      = 14;
  localparam int DT_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int INTEGRAL_W = 40;
  localparam int OPND_W     = 25;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int ACC_W      = 64;
  localparam int FRAC_W     = 24;
  localparam int TQ_W       = 40;
  localparam int MIX_W      = TQ_W + 2;
  localparam int DIV_W      = 61;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int THR_MAX    = 10000;
  localparam int US_PER_S   = 1000000;

  localparam logic [CFG_IDX_W-1:0] REG_ROLL_KP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_KD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_KI  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_KP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_KD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd5;

  localparam logic [DB_W-1:0] DEADBAND_RST = 15'd20;

  typedef struct packed {
    logic go;
    logic load;
    logic neg;
    logic sh24;
  } mac_ctrl_t;

  // Saturate to the integrator range
  function automatic logic signed [INTEGRAL_W-1:0] sat_int(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (64'sd1 <<< (INTEGRAL_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[INTEGRAL_W-1:0];
    end else if (v < lo) begin
      return lo[INTEGRAL_W-1:0];
    end
    return v[INTEGRAL_W-1:0];
  endfunction

  // Q.24 to whole units, rounding toward zero
  function automatic logic signed [TQ_W-1:0] trunc_q24(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v[ACC_W-1] ? ((v + ((64'sd1 <<< FRAC_W) - 64'sd1)) >>> FRAC_W) : (v >>> FRAC_W);
    return t[TQ_W-1:0];
  endfunction

  // {flag, throttle}
  function automatic logic [THR_W:0] clamp_motor(input logic signed [MIX_W-1:0] v);
    if (v < 0) begin
      return {1'b1, {THR_W{1'b0}}};
    end else if (v > MIX_W'(THR_MAX)) begin
      return {1'b1, THR_W'(THR_MAX)};
    end
    return {1'b0, v[THR_W-1:0]};
  endfunction

endpackage

// File: rtl/core/qrpm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrpm_mac
// Shared signed multiply-accumulate unit: registered product, then add.
// ----------------------------------------------------------------------------
module qrpm_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  qrpm_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [qrpm_pkg::OPND_W-1:0]     a_i,
  input  logic signed [qrpm_pkg::OPND_W-1:0]     b_i,
  input  logic signed [qrpm_pkg::ACC_W-1:0]      base_i,
  output logic signed [qrpm_pkg::ACC_W-1:0]      acc_o
);
  import qrpm_pkg::*;

  mac_ctrl_t               ctrl_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  base_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.go) begin
      prod_q <= a_i * b_i;
      base_q <= base_i;
    end
    acc_q <= acc_d;
  end

  always_comb begin
    prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    term     = ctrl_q.sh24 ? (prod_ext <<< FRAC_W) : prod_ext;
    if (ctrl_q.neg) begin
      term = -term;
    end
    acc_d = acc_q;
    if (ctrl_q.go) begin
      acc_d = (ctrl_q.load ? base_q : acc_q) + term;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: rtl/core/qrpm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrpm_div
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module qrpm_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [qrpm_pkg::DIV_W-1:0]      num_i,
  input  logic [qrpm_pkg::DT_W-1:0]       den_i,
  output logic                            done_o,
  output logic [qrpm_pkg::DIV_W-1:0]      quo_o
);
  import qrpm_pkg::*;

  logic                 run_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DT_W-1:0]      den_q;
  logic [DT_W:0]        rem_q;
  logic [DT_W:0]        rem_sh;
  logic                 ge;

  always_comb begin
    rem_sh = {rem_q[DT_W-1:0], quo_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(DIV_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/core/quad_rate_pid_mixer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_rate_pid_mixer_top
// Roll/pitch PID and yaw PD rate controller with four-motor mixer.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   rates, accels, throttle, dt
// out      source     out_valid_o / out_stall_i four motors, clamp flag
// cfg      sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Each transaction runs from the accept through ten multiply-accumulate steps
// (issue, accumulate and post phases) on one shared 25x25 multiplier, the
// serial yaw divider (61 quotient bits and a done strobe) and the mix step.
// One transaction is in flight at a time.
// Reset clears gains, integrators and past yaw rate; the deadband resets
// to 20. A stalled result holds in the output register; a new transaction
// may be accepted meanwhile but waits at the mix until the output is free.
// ----------------------------------------------------------------------------
module quad_rate_pid_mixer_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [qrpm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [qrpm_pkg::GAIN_W-1:0]          cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [qrpm_pkg::RATE_W-1:0]   desired_roll_rate_i,
  input  logic signed [qrpm_pkg::RATE_W-1:0]   actual_roll_rate_i,
  input  logic signed [qrpm_pkg::RATE_W-1:0]   roll_accel_i,
  input  logic signed [qrpm_pkg::RATE_W-1:0]   desired_pitch_rate_i,
  input  logic signed [qrpm_pkg::RATE_W-1:0]   actual_pitch_rate_i,
  input  logic signed [qrpm_pkg::RATE_W-1:0]   pitch_accel_i,
  input  logic signed [qrpm_pkg::RATE_W-1:0]   desired_yaw_rate_i,
  input  logic signed [qrpm_pkg::RATE_W-1:0]   actual_yaw_rate_i,
  input  logic [qrpm_pkg::THR_W-1:0]           base_throttle_i,
  input  logic [qrpm_pkg::DT_W-1:0]            step_time_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [qrpm_pkg::THR_W-1:0]           left_motor_o,
  output logic [qrpm_pkg::THR_W-1:0]           right_motor_o,
  output logic [qrpm_pkg::THR_W-1:0]           front_motor_o,
  output logic [qrpm_pkg::THR_W-1:0]           back_motor_o,
  output logic                                 clamped_o
);
  import qrpm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_MIX  = 2'd3;

  localparam logic [1:0] PH_ISSUE = 2'd0;
  localparam logic [1:0] PH_ACC   = 2'd1;
  localparam logic [1:0] PH_POST  = 2'd2;

  localparam logic [3:0] ST_R_INT = 4'd0;
  localparam logic [3:0] ST_R_P   = 4'd1;
  localparam logic [3:0] ST_R_D   = 4'd2;
  localparam logic [3:0] ST_P_INT = 4'd3;
  localparam logic [3:0] ST_P_P   = 4'd4;
  localparam logic [3:0] ST_P_D   = 4'd5;
  localparam logic [3:0] ST_Y_KD  = 4'd6;
  localparam logic [3:0] ST_Y_HI  = 4'd7;
  localparam logic [3:0] ST_Y_LO  = 4'd8;
  localparam logic [3:0] ST_Y_SUM = 4'd9;

  localparam logic signed [OPND_W-1:0] US_OPND = OPND_W'(US_PER_S);

  logic [GAIN_W-1:0] kp_q, kd_q, ki_q, ykp_q, ykd_q;
  logic [DB_W-1:0]   db_q;

  logic [1:0] state_q;
  logic [1:0] phase_q;
  logic [3:0] step_q;

  logic signed [ERR_W-1:0]      err_r_q, err_p_q, yerr_q, ydiff_q;
  logic signed [RATE_W-1:0]     acc_r_q, acc_p_q, prev_q;
  logic                         out_r_q, out_p_q;
  logic [THR_W-1:0]             base_q;
  logic [DT_W-1:0]              dt_q;
  logic signed [INTEGRAL_W-1:0] integ_r_q, integ_p_q;
  logic signed [TQ_W-1:0]       tr_q, tp_q, ty_q;
  logic signed [ERR_W+GAIN_W-1:0] m_q;
  logic                         nneg_q;
  logic signed [ACC_W-1:0]      ud_q;

  logic                         out_valid_q;
  logic [THR_W-1:0]             left_q, right_q, front_q, back_q;
  logic                         clamped_q;

  mac_ctrl_t                    mac_ctrl;
  logic signed [OPND_W-1:0]     mac_a, mac_b;
  logic signed [ACC_W-1:0]      mac_base, acc;
  logic signed [ACC_W-1:0]      acc_abs;

  logic                         div_start, div_done;
  logic [DIV_W-1:0]             quo;

  logic in_acc;
  logic signed [ERR_W-1:0]  e_r, e_p, e_y, yd;
  logic signed [RATE_W-1:0] prev_eff;
  logic signed [ERR_W:0]    db_ext;
  logic signed [MIX_W-1:0]  mb, mr, mp, my;
  logic [THR_W:0]           cl, cr, cf, cb;
  logic                     mix_go;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= '0;
      kd_q  <= '0;
      ki_q  <= '0;
      ykp_q <= '0;
      ykd_q <= '0;
      db_q  <= DEADBAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROLL_KP:  kp_q  <= cfg_wdata_i;
        REG_ROLL_KD:  kd_q  <= cfg_wdata_i;
        REG_ROLL_KI:  ki_q  <= cfg_wdata_i;
        REG_YAW_KP:   ykp_q <= cfg_wdata_i;
        REG_YAW_KD:   ykd_q <= cfg_wdata_i;
        REG_DEADBAND: db_q  <= cfg_wdata_i[DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    e_r = ERR_W'(desired_roll_rate_i) - ERR_W'(actual_roll_rate_i);
    e_p = ERR_W'(desired_pitch_rate_i) - ERR_W'(actual_pitch_rate_i);
    e_y = ERR_W'(desired_yaw_rate_i) - ERR_W'(actual_yaw_rate_i);
    prev_eff = (prev_q == '0) ? actual_yaw_rate_i : prev_q;
    yd = ERR_W'(actual_yaw_rate_i) - ERR_W'(prev_eff);
    db_ext = $signed({3'b000, db_q});
  end

  // Operand selection for the shared MAC
  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    mac_base = '0;
    if (state_q == S_MAC && phase_q == PH_ISSUE) begin
      mac_ctrl.go = 1'b1;
      case (step_q)
        ST_R_INT: begin
          mac_ctrl.load = 1'b1;
          mac_a = $signed({1'b0, ki_q});
          mac_b = OPND_W'(err_r_q);
          mac_base = ACC_W'(integ_r_q);
        end
        ST_R_P: begin
          mac_ctrl.load = 1'b1;
          mac_a = $signed({1'b0, kp_q});
          mac_b = OPND_W'(err_r_q);
          mac_base = ACC_W'(integ_r_q);
        end
        ST_R_D: begin
          mac_ctrl.neg = 1'b1;
          mac_a = $signed({1'b0, kd_q});
          mac_b = OPND_W'(acc_r_q);
        end
        ST_P_INT: begin
          mac_ctrl.load = 1'b1;
          mac_a = $signed({1'b0, ki_q});
          mac_b = OPND_W'(err_p_q);
          mac_base = ACC_W'(integ_p_q);
        end
        ST_P_P: begin
          mac_ctrl.load = 1'b1;
          mac_a = $signed({1'b0, kp_q});
          mac_b = OPND_W'(err_p_q);
          mac_base = ACC_W'(integ_p_q);
        end
        ST_P_D: begin
          mac_ctrl.neg = 1'b1;
          mac_a = $signed({1'b0, kd_q});
          mac_b = OPND_W'(acc_p_q);
        end
        ST_Y_KD: begin
          mac_ctrl.load = 1'b1;
          mac_a = $signed({1'b0, ykd_q});
          mac_b = OPND_W'(ydiff_q);
        end
        ST_Y_HI: begin
          mac_ctrl.load = 1'b1;
          mac_ctrl.sh24 = 1'b1;
          mac_a = OPND_W'($signed(m_q[ERR_W+GAIN_W-1:GAIN_W]));
          mac_b = US_OPND;
        end
        ST_Y_LO: begin
          mac_a = $signed({1'b0, m_q[GAIN_W-1:0]});
          mac_b = US_OPND;
        end
        ST_Y_SUM: begin
          mac_ctrl.load = 1'b1;
          mac_a = $signed({1'b0, ykp_q});
          mac_b = OPND_W'(yerr_q);
          mac_base = ud_q;
        end
        default: mac_ctrl.go = 1'b0;
      endcase
    end
  end

  qrpm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .base_i (mac_base),
    .acc_o  (acc)
  );

  assign acc_abs   = acc[ACC_W-1] ? -acc : acc;
  assign div_start = (state_q == S_MAC) && (phase_q == PH_POST) && (step_q == ST_Y_LO);

  qrpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_abs[DIV_W-1:0]),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    mb = MIX_W'($signed({1'b0, base_q}));
    mr = MIX_W'(tr_q);
    mp = MIX_W'(tp_q);
    my = MIX_W'(ty_q);
    cl = clamp_motor(mb + mr - my);
    cr = clamp_motor(mb - mr - my);
    cf = clamp_motor(mb - mp + my);
    cb = clamp_motor(mb + mp + my);
    mix_go = (state_q == S_MIX) && (!out_valid_q || !out_stall_i);
  end

  // Sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_ISSUE;
      step_q      <= ST_R_INT;
      out_valid_q <= 1'b0;
      integ_r_q   <= '0;
      integ_p_q   <= '0;
      prev_q      <= '0;
    end else begin
      if (mix_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            prev_q  <= actual_yaw_rate_i;
            state_q <= S_MAC;
            phase_q <= PH_ISSUE;
            step_q  <= ST_R_INT;
          end
        end
        S_MAC: begin
          case (phase_q)
            PH_ISSUE: phase_q <= PH_ACC;
            PH_ACC:   phase_q <= PH_POST;
            default: begin
              phase_q <= PH_ISSUE;
              step_q  <= step_q + 4'd1;
              case (step_q)
                ST_R_INT: if (out_r_q) integ_r_q <= sat_int(acc);
                ST_P_INT: if (out_p_q) integ_p_q <= sat_int(acc);
                ST_Y_LO:  state_q <= S_DIV;
                ST_Y_SUM: state_q <= S_MIX;
                default: ;
              endcase
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_MAC;
            phase_q <= PH_ISSUE;
            step_q  <= ST_Y_SUM;
          end
        end
        default: begin
          if (mix_go) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_r_q <= e_r;
      err_p_q <= e_p;
      yerr_q  <= e_y;
      ydiff_q <= yd;
      acc_r_q <= roll_accel_i;
      acc_p_q <= pitch_accel_i;
      out_r_q <= ((ERR_W+1)'(e_r) > db_ext) || ((ERR_W+1)'(e_r) < -db_ext);
      out_p_q <= ((ERR_W+1)'(e_p) > db_ext) || ((ERR_W+1)'(e_p) < -db_ext);
      base_q  <= base_throttle_i;
      dt_q    <= (step_time_i == '0) ? DT_W'(1) : step_time_i;
    end
    if (state_q == S_MAC && phase_q == PH_POST) begin
      case (step_q)
        ST_R_D:   tr_q <= trunc_q24(acc);
        ST_P_D:   tp_q <= trunc_q24(acc);
        ST_Y_KD:  m_q  <= acc[ERR_W+GAIN_W-1:0];
        ST_Y_LO:  nneg_q <= acc[ACC_W-1];
        ST_Y_SUM: ty_q <= trunc_q24(acc);
        default: ;
      endcase
    end
    if (state_q == S_DIV && div_done) begin
      ud_q <= nneg_q ? ACC_W'(quo) : -ACC_W'(quo);
    end
    if (mix_go) begin
      left_q    <= cl[THR_W-1:0];
      right_q   <= cr[THR_W-1:0];
      front_q   <= cf[THR_W-1:0];
      back_q    <= cb[THR_W-1:0];
      clamped_q <= cl[THR_W] | cr[THR_W] | cf[THR_W] | cb[THR_W];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_motor_o  = left_q;
  assign right_motor_o = right_q;
  assign front_motor_o = front_q;
  assign back_motor_o  = back_q;
  assign clamped_o     = clamped_q;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quadrotor rate controller and motor mixer.
// A directed table of extremes and special cases, then random rate transactions
// under several gain settings and idling modes. Results are compared field by field
// with a bit-exact predictor, or with the table values for typed rows on the first pass.
// ----------------------------------------------------------------------------
module tb;
  import qrpm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int IDLE_LIMIT   = 8000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RAND_ITEMS   = 1800;

  typedef struct {
    logic signed [RATE_W-1:0] des_roll, act_roll, roll_acc;
    logic signed [RATE_W-1:0] des_pitch, act_pitch, pitch_acc;
    logic signed [RATE_W-1:0] des_yaw, act_yaw;
    logic [THR_W-1:0]         base;
    logic [DT_W-1:0]          dt;
  } rates_t;

  typedef struct {
    logic [THR_W-1:0] left, right, front, back;
    logic             clamped;
  } motors_t;

  typedef struct {
    rates_t  stim;
    bit      typed;
    motors_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [GAIN_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [RATE_W-1:0] desired_roll_rate_i = '0, actual_roll_rate_i = '0;
  logic signed [RATE_W-1:0] roll_accel_i = '0, desired_pitch_rate_i = '0;
  logic signed [RATE_W-1:0] actual_pitch_rate_i = '0, pitch_accel_i = '0;
  logic signed [RATE_W-1:0] desired_yaw_rate_i = '0, actual_yaw_rate_i = '0;
  logic [THR_W-1:0] base_throttle_i = '0;
  logic [DT_W-1:0] step_time_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [THR_W-1:0] left_motor_o, right_motor_o, front_motor_o, back_motor_o;
  logic clamped_o;

  quad_rate_pid_mixer_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // controller copy
  logic [GAIN_W-1:0] kp_rp = '0, kd_rp = '0, ki_rp = '0, kp_yaw = '0, kd_yaw = '0;
  logic [DB_W-1:0]   deadband = DEADBAND_RST;
  longint roll_integ = 0, pitch_integ = 0, last_yaw = 0;

  motors_t motors_due[$];
  int errors = 0;
  int n_sent = 0, n_seen = 0, n_clamped = 0;
  int send_gap_pct = 0, recv_stall_pct = 0;

  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = -I64_MAX - 1;

  function automatic longint sat_sum(longint a, longint b, longint lo, longint hi);
    if (b > 0 && a > hi - b) return hi;
    if (b < 0 && a < lo - b) return lo;
    return a + b;
  endfunction

  function automatic longint rate_axis(longint des, longint act, longint acc,
                                       inout longint integ);
    longint err, hi, sum;
    err = des - act;
    hi = (longint'(1) <<< (INTEGRAL_W - 1)) - 1;
    if (err > longint'(deadband) || err < -longint'(deadband))
      integ = sat_sum(integ, longint'(ki_rp) * err, -hi - 1, hi);
    sum = sat_sum(longint'(kp_rp) * err, -(longint'(kd_rp) * acc), I64_MIN, I64_MAX);
    sum = sat_sum(sum, integ, I64_MIN, I64_MAX);
    return sum / (longint'(1) <<< FRAC_W);
  endfunction

  function automatic logic [THR_W-1:0] clip(longint v, inout logic f);
    if (v < 0) begin
      f = 1'b1;
      return '0;
    end
    if (v > THR_MAX) begin
      f = 1'b1;
      return THR_W'(THR_MAX);
    end
    return v[THR_W-1:0];
  endfunction

  function automatic motors_t mix_step(rates_t s);
    motors_t m;
    longint tr, tp, ty, yact, yerr, dtv, ysum;
    tr = rate_axis(s.des_roll, s.act_roll, s.roll_acc, roll_integ);
    tp = rate_axis(s.des_pitch, s.act_pitch, s.pitch_acc, pitch_integ);
    yact = s.act_yaw;
    yerr = longint'(s.des_yaw) - yact;
    if (last_yaw == 0) last_yaw = yact;
    dtv = (s.dt == 0) ? 1 : longint'(s.dt);
    ysum = longint'(kp_yaw) * yerr
         - (longint'(kd_yaw) * (yact - last_yaw) * US_PER_S) / dtv;
    last_yaw = yact;
    ty = ysum / (longint'(1) <<< FRAC_W);
    m.clamped = 1'b0;
    m.left  = clip(longint'(s.base) + tr - ty, m.clamped);
    m.right = clip(longint'(s.base) - tr - ty, m.clamped);
    m.front = clip(longint'(s.base) - tp + ty, m.clamped);
    m.back  = clip(longint'(s.base) + tp + ty, m.clamped);
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result monitor
  always @(posedge clk_i) begin
    motors_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_seen++;
      if (clamped_o) n_clamped++;
      if (motors_due.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        w = motors_due.pop_front();
        if (left_motor_o !== w.left) report_mismatch("left", left_motor_o, w.left);
        if (right_motor_o !== w.right) report_mismatch("right", right_motor_o, w.right);
        if (front_motor_o !== w.front) report_mismatch("front", front_motor_o, w.front);
        if (back_motor_o !== w.back) report_mismatch("back", back_motor_o, w.back);
        if (clamped_o !== w.clamped) report_mismatch("clamped", clamped_o, w.clamped);
      end
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // watchdog
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send(rates_t s, bit typed, motors_t want);
    motors_t m;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    desired_roll_rate_i <= s.des_roll;
    actual_roll_rate_i <= s.act_roll;
    roll_accel_i <= s.roll_acc;
    desired_pitch_rate_i <= s.des_pitch;
    actual_pitch_rate_i <= s.act_pitch;
    pitch_accel_i <= s.pitch_acc;
    desired_yaw_rate_i <= s.des_yaw;
    actual_yaw_rate_i <= s.act_yaw;
    base_throttle_i <= s.base;
    step_time_i <= s.dt;
    do @(posedge clk_i); while (in_stall_o);
    m = mix_step(s);
    motors_due.push_back(typed ? want : m);
    n_sent++;
  endtask

  task automatic settle();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (motors_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ROLL_KP:  kp_rp = val;
      REG_ROLL_KD:  kd_rp = val;
      REG_ROLL_KI:  ki_rp = val;
      REG_YAW_KP:   kp_yaw = val;
      REG_YAW_KD:   kd_yaw = val;
      REG_DEADBAND: deadband = val[DB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_gains(logic [GAIN_W-1:0] kp, kd, ki, ykp, ykd,
                             logic [GAIN_W-1:0] db);
    write_reg(REG_ROLL_KP, kp);
    write_reg(REG_ROLL_KD, kd);
    write_reg(REG_ROLL_KI, ki);
    write_reg(REG_YAW_KP, ykp);
    write_reg(REG_YAW_KD, ykd);
    write_reg(REG_DEADBAND, db);
  endtask

  function automatic rates_t mk(int dr, ar, ra, dp, ap, pa, dy, ay, b, t);
    rates_t s;
    s.des_roll = RATE_W'(dr); s.act_roll = RATE_W'(ar); s.roll_acc = RATE_W'(ra);
    s.des_pitch = RATE_W'(dp); s.act_pitch = RATE_W'(ap); s.pitch_acc = RATE_W'(pa);
    s.des_yaw = RATE_W'(dy); s.act_yaw = RATE_W'(ay);
    s.base = THR_W'(b); s.dt = DT_W'(t);
    return s;
  endfunction

  function automatic motors_t flat(int v, bit f);
    motors_t m;
    m.left = THR_W'(v); m.right = THR_W'(v); m.front = THR_W'(v); m.back = THR_W'(v);
    m.clamped = f;
    return m;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    if ($urandom_range(5) == 0) return '1;
    return GAIN_W'($urandom & ((32'd1 << $urandom_range(1, 24)) - 1));
  endfunction

  function automatic logic [RATE_W-1:0] rand_rate();
    case ($urandom_range(4))
      0: return RATE_W'($urandom);
      1: return RATE_W'($urandom_range(0, 800)) - 16'sd400;
      2: return RATE_W'($urandom_range(0, 60)) - 16'sd30;
      3: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return RATE_W'($urandom_range(0, 8000)) - 16'sd4000;
    endcase
  endfunction

  function automatic rates_t rand_item();
    rates_t s;
    s = mk(rand_rate(), rand_rate(), rand_rate(), rand_rate(), rand_rate(),
           rand_rate(), rand_rate(), rand_rate(), 0, 0);
    if ($urandom_range(3) == 0)
      s.act_roll = RATE_W'(s.des_roll - RATE_W'($urandom_range(0, 60)) + 30);
    if ($urandom_range(3) == 0)
      s.act_pitch = RATE_W'(s.des_pitch - RATE_W'($urandom_range(0, 60)) + 30);
    if ($urandom_range(9) == 0) s.act_yaw = '0;
    s.base = ($urandom_range(7) == 0) ? THR_W'($urandom) : THR_W'($urandom_range(0, THR_MAX));
    case ($urandom_range(9))
      0: s.dt = '0;
      1: s.dt = '1;
      2: s.dt = DT_W'($urandom);
      default: s.dt = DT_W'($urandom_range(500, 10000));
    endcase
    return s;
  endfunction

  row_t flight_table[$];

  task automatic walk_table(bit use_typed);
    foreach (flight_table[i])
      send(flight_table[i].stim, use_typed && flight_table[i].typed, flight_table[i].want);
    settle();
  endtask

  initial begin
    motors_t none;
    none = flat(0, 0);
    flight_table = '{
      '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1000), 1, flat(0, 0)},
      '{mk(0, 0, 0, 0, 0, 0, 0, 0, 10000, 1000), 1, flat(10000, 0)},
      '{mk(0, 0, 0, 0, 0, 0, 0, 0, 16383, 1000), 1, flat(10000, 1)},
      '{mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 5000, 0),
        1, flat(5000, 0)},
      '{mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 1, 65535),
        1, flat(1, 0)},
      '{mk(20, 0, 0, -20, 0, 0, 0, 0, 5000, 2000), 0, none},
      '{mk(21, 0, 0, -21, 0, 0, 0, 0, 5000, 2000), 0, none},
      '{mk(0, 20, 0, 0, -21, 0, 0, 0, 5000, 2000), 0, none},
      '{mk(0, 0, 32767, 0, 0, -32768, 100, 0, 5000, 2000), 0, none},
      '{mk(0, 0, 0, 0, 0, 0, 0, 300, 5000, 2000), 0, none},
      '{mk(0, 0, 0, 0, 0, 0, 0, -300, 5000, 0), 0, none},
      '{mk(0, 0, 0, 0, 0, 0, 0, 0, 5000, 1), 0, none},
      '{mk(0, 0, 0, 0, 0, 0, 0, 32767, 5000, 65535), 0, none},
      '{mk(32767, -32768, 0, -32768, 32767, 0, 0, -32768, 5000, 1), 0, none},
      '{mk(32767, -32768, 0, -32768, 32767, 0, 0, 5, 5000, 3000), 0, none},
      '{mk(-32768, 32767, 0, 32767, -32768, 0, 0, 5, 5000, 3000), 0, none},
      '{mk(-32768, 32767, 0, 32767, -32768, 0, 0, 5, 5000, 3000), 0, none},
      '{mk(100, 90, -5, 40, 55, 7, 12, -3, 16383, 4000), 0, none}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    walk_table(1);
    write_gains('1, '1, '1, '1, '1, '1);
    write_reg(REG_SPARE_A, 24'h00_1234);
    write_reg(REG_SPARE_B, '1);
    walk_table(0);
    write_gains(24'd4096, 24'd100, 24'd50, 24'd2048, 24'd10, 24'd0);
    walk_table(0);

    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 86; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 86; end
        default: begin send_gap_pct = 32; recv_stall_pct = 32; end
      endcase
      case (seg)
        0: write_gains('0, '0, '0, '0, '0, '0);
        4: write_gains('1, '1, '1, '1, '1, 24'h7FFF);
        default: write_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                             rand_gain(), GAIN_W'($urandom_range(0, 32767)));
      endcase
      for (int k = 0; k < RAND_ITEMS / 8; k++) send(rand_item(), 0, none);
      settle();
    end
    send_gap_pct = 0;
    recv_stall_pct = 0;
    settle();

    $display("covered %0d transactions in, %0d out, %0d with clamping, over 11 gain settings",
             n_sent, n_seen, n_clamped);
    $display("idling modes: none, sender gaps, receiver stalls, both");
    if (errors == 0 && motors_due.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, motors_due.size());
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
